/* src/lcp_pkg.sv */
// ----------------------------------------------------------------------------
// lcp_pkg: shared types and constants of the log compression pipeline
// Beat types, arithmetic widths and the log2 fraction table.
// ----------------------------------------------------------------------------
package lcp_pkg;

  localparam int SAMPLE_BITS    = 16;
  localparam int LOG_TABLE_BITS = 8;

  localparam int IN_SCALE_W  = 32;
  localparam int OUT_SCALE_W = 24;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;

  localparam int FRAC_BITS = 20;
  localparam int V_W       = SAMPLE_BITS + IN_SCALE_W;
  localparam int SHIFT_W   = $clog2(V_W);
  localparam int EXP_W     = $clog2(V_W - FRAC_BITS);
  localparam int FR_W      = 32;
  localparam int W_W       = 16;
  localparam int ROM_W     = 17;
  localparam int ROM_SIZE  = (1 << LOG_TABLE_BITS) + 1;
  localparam int PROD_W    = ROM_W + W_W;
  localparam int L2_W      = EXP_W + ROM_W;
  localparam int LOG10_W   = 15;
  localparam int P1_W      = L2_W + LOG10_W;
  localparam int P2_W      = L2_W + OUT_SCALE_W;
  localparam int PIX_W     = 8;
  localparam int NUM_STAGES = 10;

  localparam logic [V_W-1:0]     ONE_Q20     = V_W'(1) << FRAC_BITS;
  localparam logic [LOG10_W-1:0] LOG10_2_Q16 = LOG10_W'(19728);
  localparam logic [P1_W-1:0]    HALF_P1     = P1_W'(32768);
  localparam logic [PROD_W-1:0]  HALF_PROD   = PROD_W'(32768);
  localparam logic [PIX_W-1:0]   PIX_MAX     = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_SCALE  = 1'b0,
    REG_OUT_SCALE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_in_frame;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_end;
  } out_beat_t;

  typedef logic [ROM_W-1:0] rom_word_t;
  typedef rom_word_t rom_t [ROM_SIZE];

  function automatic rom_t build_log_rom();
    rom_t        rom;
    logic [63:0] y;
    logic [31:0] r;
    for (int i = 0; i < ROM_SIZE; i++) begin
      y = 64'((1 << LOG_TABLE_BITS) + i) << (30 - LOG_TABLE_BITS);
      r = '0;
      for (int k = 0; k < 24; k++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          r[0] = 1'b1;
          y    = y >> 1;
        end
      end
      rom[i] = ROM_W'((r + 32'd128) >> 8);
    end
    return rom;
  endfunction

  localparam rom_t LOG_ROM = build_log_rom();

endpackage

/* src/lcp_scale.sv */
// ----------------------------------------------------------------------------
// lcp_scale: magnitude and input scaling
// Takes the magnitude of the sample, multiplies by in_scale and adds one.
// ----------------------------------------------------------------------------
module lcp_scale (
  input  logic                                  clk,
  input  logic [1:0]                            ld,
  input  logic signed [lcp_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [lcp_pkg::IN_SCALE_W-1:0]        in_scale,
  output logic [lcp_pkg::V_W-1:0]               v
);
  import lcp_pkg::*;

  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] mag_nxt;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [V_W-1:0]         v_nxt;
  logic [V_W-1:0]         v_r;

  assign raw     = sample;
  assign mag_nxt = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
  assign v_nxt   = V_W'(mag_r) * V_W'(in_scale) + ONE_Q20;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      mag_r <= mag_nxt;
    end
    if (ld[1]) begin
      v_r <= v_nxt;
    end
  end

  assign v = v_r;

endmodule

/* src/lcp_log2.sv */
// ----------------------------------------------------------------------------
// lcp_log2: pipelined log2 in Q6.16
// Leading-one detect, normalize, table read, interpolate, combine.
// ----------------------------------------------------------------------------
module lcp_log2 (
  input  logic                      clk,
  input  logic [4:0]                ld,
  input  logic [lcp_pkg::V_W-1:0]   v,
  output logic [lcp_pkg::L2_W-1:0]  l2
);
  import lcp_pkg::*;

  logic [V_W-1:0]            v_r;
  logic [SHIFT_W-1:0]        e_nxt;
  logic [SHIFT_W-1:0]        e_r;
  logic [V_W-1:0]            norm;
  logic [FR_W-1:0]           fr_nxt;
  logic [FR_W-1:0]           fr_r;
  logic [EXP_W-1:0]          ex_nxt;
  logic [EXP_W-1:0]          ex3_r;
  logic [EXP_W-1:0]          ex4_r;
  logic [EXP_W-1:0]          ex5_r;
  logic [LOG_TABLE_BITS-1:0] idx;
  logic [LOG_TABLE_BITS:0]   idx_lo;
  logic [LOG_TABLE_BITS:0]   idx_hi;
  logic [W_W-1:0]            w_nxt;
  logic [W_W-1:0]            w_r;
  rom_word_t                 lo_nxt;
  rom_word_t                 hi_nxt;
  rom_word_t                 diff_nxt;
  rom_word_t                 lo4_r;
  rom_word_t                 lo5_r;
  rom_word_t                 diff_r;
  logic [PROD_W-1:0]         prod_nxt;
  logic [PROD_W-1:0]         prod_r;
  logic [L2_W-1:0]           l2_nxt;
  logic [L2_W-1:0]           l2_r;

  always_comb begin
    e_nxt = '0;
    for (int i = 0; i < V_W; i++) begin
      if (v[i]) begin
        e_nxt = SHIFT_W'(i);
      end
    end
  end

  assign norm   = v_r << (SHIFT_W'(V_W - 1) - e_r);
  assign fr_nxt = norm[V_W-2 -: FR_W];
  assign ex_nxt = EXP_W'(e_r - SHIFT_W'(FRAC_BITS));

  assign idx      = fr_r[FR_W-1 -: LOG_TABLE_BITS];
  assign w_nxt    = fr_r[FR_W-1-LOG_TABLE_BITS -: W_W];
  assign idx_lo   = {1'b0, idx};
  assign idx_hi   = idx_lo + (LOG_TABLE_BITS+1)'(1);
  assign lo_nxt   = LOG_ROM[idx_lo];
  assign hi_nxt   = LOG_ROM[idx_hi];
  assign diff_nxt = (hi_nxt >= lo_nxt) ? (hi_nxt - lo_nxt) : '0;

  assign prod_nxt = PROD_W'(diff_r) * PROD_W'(w_r);

  assign l2_nxt = (L2_W'(ex5_r) << 16) + L2_W'(lo5_r)
                + L2_W'((prod_r + HALF_PROD) >> 16);

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      v_r <= v;
      e_r <= e_nxt;
    end
    if (ld[1]) begin
      fr_r  <= fr_nxt;
      ex3_r <= ex_nxt;
    end
    if (ld[2]) begin
      lo4_r  <= lo_nxt;
      diff_r <= diff_nxt;
      w_r    <= w_nxt;
      ex4_r  <= ex3_r;
    end
    if (ld[3]) begin
      prod_r <= prod_nxt;
      lo5_r  <= lo4_r;
      ex5_r  <= ex4_r;
    end
    if (ld[4]) begin
      l2_r <= l2_nxt;
    end
  end

  assign l2 = l2_r;

endmodule

/* src/lcp_oscale.sv */
// ----------------------------------------------------------------------------
// lcp_oscale: log10 conversion, output scaling and saturation
// Multiplies by log10(2), rounds, multiplies by out_scale and clamps.
// ----------------------------------------------------------------------------
module lcp_oscale (
  input  logic                              clk,
  input  logic [2:0]                        ld,
  input  logic [lcp_pkg::L2_W-1:0]          l2,
  input  logic [lcp_pkg::OUT_SCALE_W-1:0]   out_scale,
  output logic [lcp_pkg::PIX_W-1:0]         pixel
);
  import lcp_pkg::*;

  localparam int HI_W = P2_W - 32;

  logic [P1_W-1:0]  p1_nxt;
  logic [P1_W-1:0]  p1_r;
  logic [L2_W-1:0]  l10;
  logic [P2_W-1:0]  p2_nxt;
  logic [P2_W-1:0]  p2_r;
  logic [HI_W-1:0]  hi;
  logic [PIX_W-1:0] pix_nxt;
  logic [PIX_W-1:0] pix_r;

  assign p1_nxt  = P1_W'(l2) * P1_W'(LOG10_2_Q16);
  assign l10     = L2_W'((p1_r + HALF_P1) >> 16);
  assign p2_nxt  = P2_W'(l10) * P2_W'(out_scale);
  assign hi      = p2_r[P2_W-1:32];
  assign pix_nxt = (hi > HI_W'(PIX_MAX)) ? PIX_MAX : hi[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p1_r <= p1_nxt;
    end
    if (ld[1]) begin
      p2_r <= p2_nxt;
    end
    if (ld[2]) begin
      pix_r <= pix_nxt;
    end
  end

  assign pixel = pix_r;

endmodule

/* src/log_compress_pixel.sv */
// ----------------------------------------------------------------------------
// log_compress_pixel: logarithmic compression of envelope samples
// pixel = sat8(log10(1 + |sample| * in_scale) * out_scale), flag passed along.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying one signed sample and a frame flag.
//   out_* : valid/ready channel carrying one 8-bit pixel and the frame flag.
//   cfg_* : write port; index 0 is in_scale (Q12.20), index 1 is out_scale
//           (Q8.16). Write only while the pipeline is empty.
// Throughput is one beat per cycle while the receiver does not stall, set by
// the ten-stage pipeline: magnitude, scale multiply, leading-one detect,
// normalize, table read, interpolation multiply, log2 combine, log10
// multiply, output scale multiply and clamp.
// Reset empties the pipeline and loads in_scale = 1.0 and out_scale = 0.
// When the receiver stalls, beats advance into empty stages ahead of them
// and input is taken as long as any stage is free; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module log_compress_pixel (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  lcp_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output lcp_pkg::out_beat_t               out_data,
  input  logic                             cfg_we,
  input  logic [lcp_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [lcp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import lcp_pkg::*;

  logic [IN_SCALE_W-1:0]  in_scale_r;
  logic [OUT_SCALE_W-1:0] out_scale_r;
  logic [NUM_STAGES-1:0]  vld_r;
  logic [NUM_STAGES-1:0]  vin;
  logic [NUM_STAGES-1:0]  rdy;
  logic [NUM_STAGES-1:0]  ld;
  logic [NUM_STAGES-1:0]  last_r;
  logic [V_W-1:0]         v;
  logic [L2_W-1:0]        l2;
  logic [PIX_W-1:0]       pixel;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_scale_r  <= IN_SCALE_W'(32'h0010_0000);
      out_scale_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_IN_SCALE:  in_scale_r  <= cfg_wdata[IN_SCALE_W-1:0];
        REG_OUT_SCALE: out_scale_r <= cfg_wdata[OUT_SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage flow control: advance into a stage that is empty or draining
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign vin = {vld_r[NUM_STAGES-2:0], in_valid};
  assign ld  = vin & rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vin[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (ld[i]) begin
        last_r[i] <= (i == 0) ? in_data.last_in_frame : last_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  lcp_scale u_scale (
    .clk      (clk),
    .ld       (ld[1:0]),
    .sample   (in_data.sample),
    .in_scale (in_scale_r),
    .v        (v)
  );

  lcp_log2 u_log2 (
    .clk (clk),
    .ld  (ld[6:2]),
    .v   (v),
    .l2  (l2)
  );

  lcp_oscale u_oscale (
    .clk       (clk),
    .ld        (ld[9:7]),
    .l2        (l2),
    .out_scale (out_scale_r),
    .pixel     (pixel)
  );

  assign in_ready           = rdy[0];
  assign out_valid          = vld_r[NUM_STAGES-1];
  assign out_data.pixel     = pixel;
  assign out_data.frame_end = last_r[NUM_STAGES-1];

`ifndef SYNTHESIS
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NUM_STAGES-1] |-> in_ready)
    else $error("input stalled with an empty output stage");

  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> $countones(vld_r) == $past($countones(vld_r)) + 1)
    else $error("accepted beat not tracked in the pipeline");

  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_valid && in_ready) && out_valid && out_ready)
    |=> $countones(vld_r) + 1 == $past($countones(vld_r)))
    else $error("delivered beat not removed from the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for log_compress_pixel
// Queues envelope samples into a valid/ready driver and computes the pixel
// of every accepted beat with a fixed-point log10 predictor that keeps its
// own log2 fraction table and scale registers. A monitor compares every
// output beat in order with the oldest prediction. Scale settings change
// only while the pipeline is empty: reset defaults, unity and zero input
// scale, both registers at full scale, then a series of random settings.
// Random idle bursts on both sides and one long receiver hold-off exercise
// back-pressure; a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb_top;
  import lcp_pkg::*;

  localparam int          TBL_BITS       = 8;
  localparam int          TBL_SIZE       = (1 << TBL_BITS) + 1;
  localparam logic [63:0] LOG10_OF_2_Q16 = 64'd19728;
  localparam int          RAND_PHASES    = 6;
  localparam int          PHASE_BEATS    = 115;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          STALL_LIMIT    = 2000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_beat_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  in_beat_t    sample_queue[$];
  out_beat_t   pixel_expect_q[$];
  logic [16:0] log2_frac_tbl [0:TBL_SIZE-1];
  logic [31:0] in_scale_now  = 32'h0010_0000;
  logic [23:0] out_scale_now = 24'd0;

  logic      in_taken    = 1'b0;
  logic      idle_on     = 1'b1;
  logic      stall_req   = 1'b0;
  logic      hold_done   = 1'b0;
  int        in_gap_left = 0;
  int        ready_gap   = 0;
  int        hold_left   = 0;
  int        quiet_cnt   = 0;
  int        beats_queued  = 0;
  int        beats_in      = 0;
  int        beats_checked = 0;
  int        mismatch_cnt  = 0;
  int        settings_cnt  = 1;
  int        sat_cnt       = 0;
  int        zero_cnt      = 0;
  out_beat_t want;
  out_beat_t got_pred;

  log_compress_pixel u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic out_beat_t predict_pixel(in_beat_t beat);
    logic [16:0] mag;
    logic [63:0] v, frac, fr, w, lo, hi, diff, l2, l10, px;
    int unsigned e, idx;
    out_beat_t   res;
    mag = beat.sample[SAMPLE_BITS-1] ? (17'h10000 - {1'b0, beat.sample})
                                     : {1'b0, beat.sample};
    v = 64'(mag) * 64'(in_scale_now) + (64'd1 << 20);
    e = 63;
    while (e > 0 && v[e] == 1'b0) e--;
    frac = v - (64'd1 << e);
    fr   = (frac << (63 - e)) >> 31;
    idx  = fr[31:24];
    w    = {48'd0, fr[23:8]};
    lo   = 64'(log2_frac_tbl[idx]);
    hi   = 64'(log2_frac_tbl[idx + 1]);
    diff = (hi >= lo) ? hi - lo : 64'd0;
    l2   = (64'(e - 20) << 16) + lo + ((diff * w + 64'd32768) >> 16);
    l10  = (l2 * LOG10_OF_2_Q16 + 64'd32768) >> 16;
    px   = (l10 * 64'(out_scale_now)) >> 32;
    res.pixel     = (px > 64'd255) ? 8'd255 : px[7:0];
    res.frame_end = beat.last_in_frame;
    return res;
  endfunction

  function automatic logic [15:0] corner(int k);
    case (k)
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return 16'h7FFF;
      4:       return 16'h8000;
      5:       return 16'h5555;
      6:       return 16'hAAAA;
      default: return 16'h0002;
    endcase
  endfunction

  task automatic queue_sample(logic [15:0] s, logic flag);
    in_beat_t b;
    b.sample        = s;
    b.last_in_frame = flag;
    sample_queue.push_back(b);
    beats_queued++;
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_IN_SCALE:  in_scale_now  = val;
      REG_OUT_SCALE: out_scale_now = val[23:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (beats_checked != beats_queued) @(negedge clk);
    repeat (NUM_STAGES + 2) @(negedge clk);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap_left > 0) begin
        in_gap_left = in_gap_left - 1;
        in_valid <= 1'b0;
      end else if (sample_queue.size() != 0 && idle_on && $urandom_range(0, 7) == 0) begin
        in_gap_left = $urandom_range(0, 4);
        in_valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data  <= sample_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap = ready_gap - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        ready_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixel_expect_q.size() == 0) begin
          $error("unexpected beat: pixel %0d frame_end %0b", out_data.pixel,
                 out_data.frame_end);
          mismatch_cnt++;
        end else begin
          want = pixel_expect_q.pop_front();
          beats_checked++;
          if (out_data.pixel !== want.pixel) begin
            $error("pixel: expected %0d, actual %0d", want.pixel, out_data.pixel);
            mismatch_cnt++;
          end
          if (out_data.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, actual %0b", want.frame_end,
                   out_data.frame_end);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        got_pred = predict_pixel(in_data);
        pixel_expect_q.push_back(got_pred);
        beats_in++;
        if (got_pred.pixel == 8'd255) sat_cnt++;
        if (got_pred.pixel == 8'd0) zero_cnt++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cnt = 0;
    else quiet_cnt = quiet_cnt + 1;
    if (quiet_cnt >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] y;
    logic [31:0] r;
    logic [31:0] isc;
    logic [23:0] osc;
    logic [15:0] s;
    for (int i = 0; i < TBL_SIZE; i++) begin
      y = 64'((1 << TBL_BITS) + i) << (30 - TBL_BITS);
      r = '0;
      for (int k = 0; k < 24; k++) begin
        y = (y * y) >> 30;
        r = r << 1;
        if (y >= (64'd2 << 30)) begin
          r[0] = 1'b1;
          y    = y >> 1;
        end
      end
      log2_frac_tbl[i] = 17'((r + 32'd128) >> 8);
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: zero output scale
    for (int k = 0; k < 5; k++) queue_sample(corner(k), k[0]);
    wait_idle();

    write_reg(REG_IN_SCALE, 32'h0010_0000);
    write_reg(REG_OUT_SCALE, 32'h0038_7A00);
    settings_cnt++;
    for (int k = 0; k < 8; k++) queue_sample(corner(k), k == 7);
    wait_idle();

    // zero input scale
    write_reg(REG_IN_SCALE, 32'h0000_0000);
    settings_cnt++;
    for (int k = 0; k < 5; k++) queue_sample(corner(k), k[0]);
    wait_idle();

    // both registers at full scale
    write_reg(REG_IN_SCALE, 32'hFFFF_FFFF);
    write_reg(REG_OUT_SCALE, 32'h00FF_FFFF);
    settings_cnt++;
    for (int k = 0; k < 4; k++) queue_sample(corner(k + 1), !k[0]);
    wait_idle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       isc = $urandom;
        1:       isc = $urandom_range(0, 32'h0020_0000);
        2:       isc = $urandom_range(0, 32'h0000_FFFF);
        default: isc = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0010_0000;
      endcase
      case ($urandom_range(0, 3))
        0:       osc = 24'($urandom_range(0, 24'h3F_FFFF));
        1:       osc = 24'($urandom);
        2:       osc = 24'($urandom_range(0, 24'h0F_FFFF));
        default: osc = $urandom_range(0, 1) ? 24'hFF_FFFF : 24'h00_0000;
      endcase
      write_reg(REG_IN_SCALE, isc);
      write_reg(REG_OUT_SCALE, {8'd0, osc});
      settings_cnt++;
      if (p == RAND_PHASES - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        case ($urandom_range(0, 3))
          0: s = 16'($urandom);
          1: begin
            s = 16'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) s = -s;
          end
          2: s = corner($urandom_range(0, 7));
          default: begin
            s = 16'($urandom_range(0, 16'h7FFF) >> $urandom_range(0, 14));
            if ($urandom_range(0, 1) == 1) s = -s;
          end
        endcase
        queue_sample(s, $urandom_range(0, 31) == 0);
      end
      if (p == 1) stall_req = 1'b1;
      wait_idle();
    end

    repeat (20) @(negedge clk);
    $display("summary: %0d samples checked across %0d scale settings", beats_in,
             settings_cnt);
    $display("summary: %0d saturated and %0d zero pixels, one long receiver hold-off",
             sat_cnt, zero_cnt);
    if (mismatch_cnt == 0 && pixel_expect_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* log_compress_pixel.f */
src/lcp_pkg.sv
src/lcp_scale.sv
src/lcp_log2.sv
src/lcp_oscale.sv
src/log_compress_pixel.sv
bench/tb_top.sv
